// ===== rtl/srlb_pkg.sv =====
// Package for the source rate limiter with blocklist.
// Holds register defaults, register indexes, verdict codes and the
// controller/datapath command and status types. No dependencies.
package srlb_pkg;

  localparam int unsigned BLOCK_ENTRIES_DEF = 64;
  localparam int unsigned RATE_ENTRIES_DEF  = 64;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_NEW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_REPEAT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_MS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CALM_MS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VIOL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_SEC     = 3'd5;

  // register reset values
  localparam logic [15:0] BLOCK_NEW_RST    = 16'd180;
  localparam logic [15:0] BLOCK_REPEAT_RST = 16'd60;
  localparam logic [15:0] FAST_MS_RST      = 16'd50;
  localparam logic [15:0] CALM_MS_RST      = 16'd300;
  localparam logic [2:0]  MAX_VIOL_RST     = 3'd4;
  localparam logic [15:0] IDLE_SEC_RST     = 16'd10;

  // verdict codes
  localparam logic [2:0] VERDICT_LISTED  = 3'd0;
  localparam logic [2:0] VERDICT_BAD_SIG = 3'd1;
  localparam logic [2:0] VERDICT_FAST    = 3'd2;
  localparam logic [2:0] VERDICT_PASS    = 3'd3;
  localparam logic [2:0] VERDICT_BAD_CMD = 3'd4;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] unblock_sec;
  } block_entry_t;

  typedef struct packed {
    logic [31:0] seen_sec;
    logic [31:0] last_ms;
    logic [2:0]  count;
  } rate_entry_t;

  typedef struct packed {
    logic load;
    logic bscan;
    logic rscan;
    logic calc;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bdone;
    logic rdone;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== rtl/source_rate_limiter_blocklist_core.sv =====
// Source rate limiter with blocklist, top level.
// Each item passes accept, the entry-by-entry scans of the block and rate tables,
// evaluate and commit into the result register; a new input transfer is taken
// only once the controller is back in idle after the commit of the last item.
// Reset (rst_ni low, asynchronous) restores register defaults and marks every
// table entry invalid at once through per-entry valid flops; no clearing pass.
module source_rate_limiter_blocklist_core #(
  parameter int unsigned BLOCK_ENTRIES = srlb_pkg::BLOCK_ENTRIES_DEF,
  parameter int unsigned RATE_ENTRIES  = srlb_pkg::RATE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes, to be taken only while idle; the block does not enforce it
  input  logic                             cfg_wr_en_i,
  input  logic [srlb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srlb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // packet event channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [31:0]                      src_ip_i,
  input  logic [31:0]                      now_sec_i,
  input  logic [31:0]                      now_ms_i,
  input  logic                             sig_ok_i,
  input  logic                             cmd_ok_i,
  // verdict channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       verdict_o,
  output logic [2:0]                       violations_o,
  output logic                             table_full_o
);

  // Controller walks: accept, block scan (drop expired, look up source, find
  // lowest free slot), rate scan (look up source, drop idle entries on the
  // signed path, find lowest free slot), evaluate the gap and unblock time,
  // then commit table writes and load the result register. The result
  // register lets the next transfer be accepted while a verdict still waits.
  srlb_pkg::ctrl_cmd_t    cmd;
  srlb_pkg::ctrl_status_t st;

  srlb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  srlb_datapath #(
    .BLOCK_ENTRIES (BLOCK_ENTRIES),
    .RATE_ENTRIES  (RATE_ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .src_ip_i     (src_ip_i),
    .now_sec_i    (now_sec_i),
    .now_ms_i     (now_ms_i),
    .sig_ok_i     (sig_ok_i),
    .cmd_ok_i     (cmd_ok_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .verdict_o    (verdict_o),
    .violations_o (violations_o),
    .table_full_o (table_full_o)
  );

endmodule

// ===== rtl/srlb_ctrl.sv =====
// Controller state machine for the source rate limiter with blocklist.
// Sequences accept, block scan, rate scan, evaluate and commit.
// Depends on srlb_pkg.
module srlb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  srlb_pkg::ctrl_status_t st_i,
  output srlb_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_BSCAN  = 5'b00010,
    S_RSCAN  = 5'b00100,
    S_CALC   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_BSCAN;
        end
      end
      S_BSCAN: begin
        cmd_o.bscan = 1'b1;
        if (st_i.bdone) state_d = S_RSCAN;
      end
      S_RSCAN: begin
        cmd_o.rscan = 1'b1;
        if (st_i.rdone) state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register can take the result
        if (st_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/srlb_datapath.sv =====
// Datapath for the source rate limiter with blocklist: configuration
// registers, both tables with their valid bits, scan pipes and result register.
// Depends on srlb_pkg.
module srlb_datapath #(
  parameter int unsigned BLOCK_ENTRIES = srlb_pkg::BLOCK_ENTRIES_DEF,
  parameter int unsigned RATE_ENTRIES  = srlb_pkg::RATE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  srlb_pkg::ctrl_cmd_t              cmd_i,
  output srlb_pkg::ctrl_status_t           st_o,
  input  logic                             cfg_wr_en_i,
  input  logic [srlb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srlb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [31:0]                      src_ip_i,
  input  logic [31:0]                      now_sec_i,
  input  logic [31:0]                      now_ms_i,
  input  logic                             sig_ok_i,
  input  logic                             cmd_ok_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       verdict_o,
  output logic [2:0]                       violations_o,
  output logic                             table_full_o
);

  localparam int unsigned BAW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int unsigned RAW = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
  localparam int unsigned BCW = $clog2(BLOCK_ENTRIES + 1);
  localparam int unsigned RCW = $clog2(RATE_ENTRIES + 1);
  localparam logic [BAW-1:0] BLAST = BAW'(BLOCK_ENTRIES - 1);
  localparam logic [RAW-1:0] RLAST = RAW'(RATE_ENTRIES - 1);
  localparam logic [BCW-1:0] BEND  = BCW'(BLOCK_ENTRIES);
  localparam logic [RCW-1:0] REND  = RCW'(RATE_ENTRIES);

  // configuration registers
  logic [15:0] block_new_q, block_repeat_q, fast_ms_q, calm_ms_q, idle_sec_q;
  logic [2:0]  max_viol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_new_q    <= srlb_pkg::BLOCK_NEW_RST;
      block_repeat_q <= srlb_pkg::BLOCK_REPEAT_RST;
      fast_ms_q      <= srlb_pkg::FAST_MS_RST;
      calm_ms_q      <= srlb_pkg::CALM_MS_RST;
      max_viol_q     <= srlb_pkg::MAX_VIOL_RST;
      idle_sec_q     <= srlb_pkg::IDLE_SEC_RST;
    end else if (cfg_wr_en_i) begin
      case (cfg_index_i)
        srlb_pkg::REG_BLOCK_NEW:    block_new_q    <= cfg_data_i;
        srlb_pkg::REG_BLOCK_REPEAT: block_repeat_q <= cfg_data_i;
        srlb_pkg::REG_FAST_MS:      fast_ms_q      <= cfg_data_i;
        srlb_pkg::REG_CALM_MS:      calm_ms_q      <= cfg_data_i;
        srlb_pkg::REG_MAX_VIOL:     max_viol_q     <= cfg_data_i[2:0];
        srlb_pkg::REG_IDLE_SEC:     idle_sec_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched item
  logic [31:0] ip_q, nsec_q, nms_q;
  logic        sig_q, cmdok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ip_q    <= src_ip_i;
      nsec_q  <= now_sec_i;
      nms_q   <= now_ms_i;
      sig_q   <= sig_ok_i;
      cmdok_q <= cmd_ok_i;
    end
  end

  // tables
  srlb_pkg::block_entry_t bmem [BLOCK_ENTRIES];
  logic [31:0]            raddr_mem [RATE_ENTRIES];
  srlb_pkg::rate_entry_t  rdata_mem [RATE_ENTRIES];
  logic [BLOCK_ENTRIES-1:0] bvalid_q;
  logic [RATE_ENTRIES-1:0]  rvalid_q;

  srlb_pkg::block_entry_t brd_q;
  logic [31:0]            rard_q;
  srlb_pkg::rate_entry_t  rdrd_q;

  // scan counters and pipe
  logic [BCW-1:0] bidx_q;
  logic [RCW-1:0] ridx_q;
  logic           bpv_q, rpv_q;
  logic [BAW-1:0] bix1_q;
  logic [RAW-1:0] rix1_q;
  logic           b_issue, r_issue;

  assign b_issue = cmd_i.bscan && (bidx_q != BEND);
  assign r_issue = cmd_i.rscan && (ridx_q != REND);

  // scan findings
  logic           bfound_q, bfree_ok_q, rfound_q, rfree_ok_q;
  logic [BAW-1:0] bfree_q;
  logic [RAW-1:0] rfi_q, rfree_q;
  logic [31:0]    rlast_q;
  logic [2:0]     rcnt_q;

  // evaluate results
  logic        fast_q, calm_q;
  logic [31:0] until_q;

  // block scan processing
  logic b_v, b_exp, b_match, b_free;
  always_comb begin
    b_v     = bvalid_q[bix1_q];
    b_exp   = bpv_q && b_v && (brd_q.unblock_sec <= nsec_q);
    b_match = bpv_q && b_v && !b_exp && (brd_q.addr == ip_q) && !bfound_q;
    b_free  = bpv_q && (!b_v || b_exp) && !bfree_ok_q;
  end

  // rate scan processing: drop idle entries only on the signed path
  logic r_v, r_match, r_drop, r_free, drop_en;
  logic [32:0] r_idle_sum;
  always_comb begin
    drop_en    = !bfound_q && sig_q;
    r_v        = rvalid_q[rix1_q];
    r_idle_sum = {1'b0, rdrd_q.seen_sec} + 33'(idle_sec_q);
    r_match    = rpv_q && r_v && (rard_q == ip_q) && !rfound_q;
    r_drop     = rpv_q && r_v && !r_match && drop_en && (r_idle_sum <= {1'b0, nsec_q});
    r_free     = rpv_q && (!r_v || r_drop) && !rfree_ok_q;
  end

  assign st_o.bdone = bpv_q && (bix1_q == BLAST);
  assign st_o.rdone = rpv_q && (rix1_q == RLAST);

  // commit decisions
  logic [3:0]  cnt1;
  logic [2:0]  new_cnt, viol;
  logic [2:0]  verdict;
  logic        fast_block, do_block, full, rins, rupd;
  always_comb begin
    cnt1       = {1'b0, rcnt_q} + 4'd1;
    new_cnt    = rcnt_q;
    fast_block = 1'b0;
    do_block   = 1'b0;
    full       = 1'b0;
    rins       = 1'b0;
    rupd       = 1'b0;
    viol       = rfound_q ? rcnt_q : 3'd0;
    verdict    = srlb_pkg::VERDICT_PASS;
    if (bfound_q) begin
      verdict = srlb_pkg::VERDICT_LISTED;
    end else if (!sig_q) begin
      verdict  = srlb_pkg::VERDICT_BAD_SIG;
      do_block = 1'b1;
    end else begin
      if (rfound_q) begin
        rupd = 1'b1;
        if (fast_q) begin
          if (cnt1 > {1'b0, max_viol_q}) begin
            fast_block = 1'b1;
          end else begin
            new_cnt = cnt1[2:0];
          end
        end else if (calm_q) begin
          new_cnt = 3'd0;
        end
        viol = fast_block ? 3'd0 : new_cnt;
      end else begin
        viol    = 3'd0;
        new_cnt = 3'd0;
        if (rfree_ok_q) rins = 1'b1;
        else            full = 1'b1;
      end
      if (fast_block) begin
        verdict  = srlb_pkg::VERDICT_FAST;
        do_block = 1'b1;
      end else if (!cmdok_q) begin
        verdict  = srlb_pkg::VERDICT_BAD_CMD;
        do_block = 1'b1;
      end
    end
    if (do_block && !bfree_ok_q) full = 1'b1;
  end

  logic commit_b, commit_rd, commit_ra;
  assign commit_b  = cmd_i.commit && do_block && bfree_ok_q;
  assign commit_rd = cmd_i.commit && (rupd || rins);
  assign commit_ra = cmd_i.commit && rins;

  logic [RAW-1:0] rwa;
  assign rwa = rupd ? rfi_q : rfree_q;

  // memories: registered reads, one write port each
  always_ff @(posedge clk_i) begin
    if (b_issue) brd_q <= bmem[bidx_q[BAW-1:0]];
    if (commit_b) bmem[bfree_q] <= '{addr: ip_q, unblock_sec: until_q};
  end

  always_ff @(posedge clk_i) begin
    if (r_issue) begin
      rard_q <= raddr_mem[ridx_q[RAW-1:0]];
      rdrd_q <= rdata_mem[ridx_q[RAW-1:0]];
    end
    if (commit_ra) raddr_mem[rfree_q] <= ip_q;
    if (commit_rd) rdata_mem[rwa] <= '{seen_sec: nsec_q, last_ms: nms_q, count: new_cnt};
  end

  // valid bits and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q   <= '0;
      rvalid_q   <= '0;
      bidx_q     <= '0;
      ridx_q     <= '0;
      bpv_q      <= 1'b0;
      rpv_q      <= 1'b0;
      bfound_q   <= 1'b0;
      bfree_ok_q <= 1'b0;
      rfound_q   <= 1'b0;
      rfree_ok_q <= 1'b0;
    end else begin
      bpv_q <= b_issue;
      rpv_q <= r_issue;
      if (b_issue) bidx_q <= bidx_q + BCW'(1);
      if (r_issue) ridx_q <= ridx_q + RCW'(1);
      if (cmd_i.load) begin
        bidx_q     <= '0;
        ridx_q     <= '0;
        bfound_q   <= 1'b0;
        bfree_ok_q <= 1'b0;
        rfound_q   <= 1'b0;
        rfree_ok_q <= 1'b0;
      end
      if (b_exp)   bvalid_q[bix1_q] <= 1'b0;
      if (b_match) bfound_q <= 1'b1;
      if (b_free)  bfree_ok_q <= 1'b1;
      if (r_drop)  rvalid_q[rix1_q] <= 1'b0;
      if (r_match) rfound_q <= 1'b1;
      if (r_free)  rfree_ok_q <= 1'b1;
      if (commit_b) bvalid_q[bfree_q] <= 1'b1;
      if (commit_ra) rvalid_q[rfree_q] <= 1'b1;
      if (cmd_i.commit && fast_block) rvalid_q[rfi_q] <= 1'b0;
    end
  end

  // scan payload captures
  logic [32:0] usum;
  always_comb begin
    usum = {1'b0, nsec_q} + 33'(bfound_q ? block_repeat_q : block_new_q);
  end

  always_ff @(posedge clk_i) begin
    if (b_issue) bix1_q <= bidx_q[BAW-1:0];
    if (r_issue) rix1_q <= ridx_q[RAW-1:0];
    if (b_free) bfree_q <= bix1_q;
    if (r_free) rfree_q <= rix1_q;
    if (r_match) begin
      rfi_q   <= rix1_q;
      rlast_q <= rdrd_q.last_ms;
      rcnt_q  <= rdrd_q.count;
    end
    if (cmd_i.calc) begin
      fast_q  <= (nms_q - rlast_q) <= 32'(fast_ms_q);
      calm_q  <= (nms_q - rlast_q) > 32'(calm_ms_q);
      until_q <= usum[32] ? 32'hFFFF_FFFF : usum[31:0];
    end
  end

  // result register
  logic       out_valid_q;
  logic [2:0] verdict_q, viol_q;
  logic       full_q;

  assign st_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      verdict_q <= verdict;
      viol_q    <= viol;
      full_q    <= full;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = verdict_q;
  assign violations_o = viol_q;
  assign table_full_o = full_q;

endmodule

// ===== verif/tb_source_rate_limiter_blocklist_core.sv =====
// Testbench for source_rate_limiter_blocklist_core: drives packet events and
// checks each verdict against a behavioural predictor held in this file.
// Depends on rtl/srlb_pkg.sv and the core RTL only.
`timescale 1ns / 1ps

module tb_source_rate_limiter_blocklist_core;

  localparam int NB = 64;
  localparam int NR = 64;
  localparam int DRAIN_CYCLES = NB + NR + 12;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS_PER_PHASE = 300;

  typedef struct {
    bit [31:0] ip;
    bit [31:0] sec;
    bit [31:0] ms;
    bit        sig;
    bit        cmd;
  } packet_t;

  typedef struct {
    bit [2:0] verdict;
    bit [2:0] viol;
    bit       full;
  } decision_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_wr_en_i = 1'b0;
  logic [srlb_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [srlb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [31:0]                     src_ip_i = '0;
  logic [31:0]                     now_sec_i = '0;
  logic [31:0]                     now_ms_i = '0;
  logic                            sig_ok_i = 1'b0;
  logic                            cmd_ok_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [2:0]                      verdict_o;
  logic [2:0]                      violations_o;
  logic                            table_full_o;

  source_rate_limiter_blocklist_core uut (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .src_ip_i, .now_sec_i, .now_ms_i, .sig_ok_i, .cmd_ok_i,
    .out_valid_o, .out_stall_i, .verdict_o, .violations_o, .table_full_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and both tables
  // ---------------------------------------------------------------------------
  bit [15:0] new_block_sec, repeat_block_sec, fast_gap_ms, calm_gap_ms, idle_limit_sec;
  bit [2:0]  viol_limit;

  bit        listed_v[NB];
  bit [31:0] listed_ip[NB];
  bit [31:0] listed_until[NB];
  bit        tracked_v[NR];
  bit [31:0] tracked_ip[NR];
  bit [31:0] tracked_seen[NR];
  bit [31:0] tracked_last_ms[NR];
  bit [2:0]  tracked_count[NR];

  decision_t decision_q[$];
  int        fails = 0;
  int        packets_sent = 0;
  int        verdicts_checked = 0;
  int        verdict_seen[5];
  int        full_seen = 0;
  bit        smooth_sender = 1'b0;
  int        burst_left = 0;

  function automatic int find_listed(bit [31:0] ip);
    for (int i = 0; i < NB; i++) if (listed_v[i] && listed_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int find_tracked(bit [31:0] ip);
    for (int i = 0; i < NR; i++) if (tracked_v[i] && tracked_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic bit [31:0] until_sec(bit [31:0] nsec, bit [15:0] len);
    bit [32:0] sum;
    sum = {1'b0, nsec} + len;
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // list a source; returns 1 when the blocklist had no free slot
  function automatic bit list_source(bit [31:0] ip, bit [31:0] nsec);
    int k;
    k = find_listed(ip);
    if (k >= 0) begin
      listed_until[k] = until_sec(nsec, repeat_block_sec);
      return 1'b0;
    end
    for (int i = 0; i < NB; i++) begin
      if (!listed_v[i]) begin
        listed_v[i] = 1'b1;
        listed_ip[i] = ip;
        listed_until[i] = until_sec(nsec, new_block_sec);
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic decision_t judge_packet(packet_t p);
    decision_t d;
    int        own, r;
    bit        fast_block, stored;
    bit [31:0] gap;
    bit [3:0]  c;
    d = '{verdict: srlb_pkg::VERDICT_PASS, viol: 3'd0, full: 1'b0};
    for (int i = 0; i < NB; i++)
      if (listed_v[i] && listed_until[i] <= p.sec) listed_v[i] = 1'b0;
    if (find_listed(p.ip) >= 0) begin
      d.verdict = srlb_pkg::VERDICT_LISTED;
    end else if (!p.sig) begin
      d.full |= list_source(p.ip, p.sec);
      d.verdict = srlb_pkg::VERDICT_BAD_SIG;
    end else begin
      own = -1;
      fast_block = 1'b0;
      // drop idle entries, sparing the first one that belongs to this source
      for (int i = 0; i < NR; i++) begin
        if (!tracked_v[i]) continue;
        if (own < 0 && tracked_ip[i] == p.ip) own = i;
        else if ({1'b0, tracked_seen[i]} + idle_limit_sec <= {1'b0, p.sec})
          tracked_v[i] = 1'b0;
      end
      if (own >= 0) begin
        gap = p.ms - tracked_last_ms[own];
        tracked_seen[own] = p.sec;
        if (gap <= fast_gap_ms) begin
          c = tracked_count[own] + 4'd1;
          if (c > viol_limit) begin
            d.full |= list_source(p.ip, p.sec);
            tracked_v[own] = 1'b0;
            fast_block = 1'b1;
          end else begin
            tracked_count[own] = c[2:0];
          end
        end else if (gap > calm_gap_ms) begin
          tracked_count[own] = 3'd0;
        end
        if (!fast_block) tracked_last_ms[own] = p.ms;
      end else begin
        stored = 1'b0;
        for (int i = 0; i < NR && !stored; i++) begin
          if (!tracked_v[i]) begin
            tracked_v[i] = 1'b1;
            tracked_ip[i] = p.ip;
            tracked_seen[i] = p.sec;
            tracked_last_ms[i] = p.ms;
            tracked_count[i] = 3'd0;
            stored = 1'b1;
          end
        end
        if (!stored) d.full = 1'b1;
      end
      if (fast_block) begin
        d.verdict = srlb_pkg::VERDICT_FAST;
      end else if (!p.cmd) begin
        d.full |= list_source(p.ip, p.sec);
        d.verdict = srlb_pkg::VERDICT_BAD_CMD;
      end
    end
    r = find_tracked(p.ip);
    d.viol = (r >= 0) ? tracked_count[r] : 3'd0;
    return d;
  endfunction

  function automatic packet_t pkt(bit [31:0] ip, bit [31:0] sec, bit [31:0] ms,
                                  bit sig, bit cmd);
    packet_t p;
    p.ip = ip; p.sec = sec; p.ms = ms; p.sig = sig; p.cmd = cmd;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------
  // present one packet, hold it until the transfer, then record its verdict
  task automatic send_packet(packet_t p);
    int gap;
    in_valid_i <= 1'b1;
    src_ip_i   <= p.ip;
    now_sec_i  <= p.sec;
    now_ms_i   <= p.ms;
    sig_ok_i   <= p.sig;
    cmd_ok_i   <= p.cmd;
    do @(posedge clk_i); while (in_stall_o);
    decision_q.push_back(judge_packet(p));
    packets_sent++;
    // burst/gap pattern of the sender
    if (!smooth_sender && burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // drop valid and hold until every verdict in flight has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk_i);
  endtask

  // write all six registers while the core is idle
  task automatic write_registers(bit [15:0] bnew, bit [15:0] brep, bit [15:0] fast,
                                 bit [15:0] calm, bit [2:0] maxv, bit [15:0] idle);
    logic [srlb_pkg::CFG_IDX_W-1:0] idx[6];
    bit   [15:0]                    val[6];
    idx = '{srlb_pkg::REG_BLOCK_NEW, srlb_pkg::REG_BLOCK_REPEAT, srlb_pkg::REG_FAST_MS,
            srlb_pkg::REG_CALM_MS, srlb_pkg::REG_MAX_VIOL, srlb_pkg::REG_IDLE_SEC};
    val = '{bnew, brep, fast, calm, {13'd0, maxv}, idle};
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
    end
    cfg_wr_en_i <= 1'b0;
    new_block_sec = bnew; repeat_block_sec = brep; fast_gap_ms = fast;
    calm_gap_ms = calm; viol_limit = maxv; idle_limit_sec = idle;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: free-running, choppy and long-stall modes
  // ---------------------------------------------------------------------------
  int unsigned stall_cycle = 0;
  int          stall_run = 0;

  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle >> 9) % 3)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (stall_run == 0) begin
          stall_run <= $urandom_range(1, 40);
          out_stall_i <= ~out_stall_i;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Verdict checker: compare every output transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    decision_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (decision_q.size() == 0) begin
        $error("verdict transfer with no packet outstanding");
        fails++;
      end else begin
        want = decision_q.pop_front();
        verdicts_checked++;
        if (want.verdict < 5) verdict_seen[want.verdict]++;
        if (want.full) full_seen++;
        if (verdict_o !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, verdict_o);
          fails++;
        end
        if (violations_o !== want.viol) begin
          $error("violations: expected %0d, got %0d", want.viol, violations_o);
          fails++;
        end
        if (table_full_o !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, table_full_o);
          fails++;
        end
      end
    end
  end

  // Watchdog: abort when no transfer on either channel for too long
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d verdicts outstanding",
               WATCHDOG_LIMIT, decision_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // default registers: pass, violation climb, too fast, listed, bad signature,
  // bad command, block expiry, saturated unblock time and millisecond wrap
  task automatic test_default_behaviour();
    bit [31:0] a, c, d, e;
    a = 32'h0A00_0001; c = 32'h0000_0000; d = 32'h8000_0000; e = 32'h5555_AAAA;
    send_packet(pkt(a, 1000, 10000, 1'b1, 1'b1));
    for (int i = 1; i <= 5; i++) send_packet(pkt(a, 1000, 10000 + 10 * i, 1'b1, 1'b1));
    send_packet(pkt(a, 1001, 20000, 1'b1, 1'b1));
    send_packet(pkt(32'hFFFF_FFFF, 1001, 20001, 1'b0, 1'b1));
    send_packet(pkt(c, 1002, 20002, 1'b1, 1'b0));
    send_packet(pkt(c, 1180, 30000, 1'b1, 1'b1));
    send_packet(pkt(a, 1180, 30001, 1'b1, 1'b1));
    send_packet(pkt(e, 1181, 32'hFFFF_FFF0, 1'b1, 1'b1));
    send_packet(pkt(e, 1181, 32'h0000_0010, 1'b1, 1'b1));
    send_packet(pkt(e, 1182, 32'h0000_01A0, 1'b1, 1'b1));
    send_packet(pkt(d, 32'hFFFF_FFF0, 40000, 1'b0, 1'b0));
    send_packet(pkt(d, 32'hFFFF_FFFE, 40001, 1'b1, 1'b1));
    send_packet(pkt(32'h1234_5678, 32'hFFFF_FFFF, 40002, 1'b1, 1'b0));
    wait_drained();
  endtask

  // fill the rate table and the blocklist past their sizes
  task automatic test_tables_full();
    for (int i = 0; i < NR + 2; i++)
      send_packet(pkt(32'hC0A8_0000 + i, 2000, 50000 + i, 1'b1, 1'b1));
    for (int i = 0; i < NB + 2; i++)
      send_packet(pkt(32'hAC10_0000 + i, 2000, 60000 + i, 1'b0, 1'b1));
    wait_drained();
  endtask

  // random traffic from a small pool of sources with advancing clocks
  task automatic run_traffic_phase(bit [31:0] sec_base, int items, bit pause_midway);
    bit [31:0] pool[8];
    bit [31:0] sec, ms, ip;
    int        span;
    sec = sec_base;
    ms = $urandom();
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    span = 2 * (fast_gap_ms > calm_gap_ms ? fast_gap_ms : calm_gap_ms) + 20;
    for (int n = 0; n < items; n++) begin
      if (pause_midway && n % 97 == 50) wait_drained();
      ip = ($urandom_range(0, 7) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 15) == 0) ms += $urandom();
      else if ($urandom_range(0, 2) == 0) ms += $urandom_range(0, fast_gap_ms + 2);
      else ms += $urandom_range(0, span);
      if ($urandom_range(0, 3) == 0) sec += $urandom_range(0, 3);
      if ($urandom_range(0, 31) == 0) sec += $urandom_range(0, 300);
      // occasional stray timestamp
      send_packet(pkt(ip, ($urandom_range(0, 49) == 0) ? $urandom() : sec, ms,
                      $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0));
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(5000, RANDOM_ITEMS_PER_PHASE, 1'b1);
    write_registers(16'd5, 16'd3, 16'd100, 16'd200, 3'd2, 16'd3);
    smooth_sender = 1'b1;
    run_traffic_phase(20000, RANDOM_ITEMS_PER_PHASE, 1'b0);
    smooth_sender = 1'b0;
    write_registers(16'd0, 16'd0, 16'd0, 16'd0, 3'd0, 16'd1);
    run_traffic_phase(32'hFFFF_FE00, RANDOM_ITEMS_PER_PHASE, 1'b0);
    write_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF);
    run_traffic_phase(32'h7FFF_FF00, RANDOM_ITEMS_PER_PHASE, 1'b0);
    // fast threshold above calm threshold: overlapping gaps count as violations
    write_registers(16'($urandom_range(1, 400)), 16'($urandom_range(0, 400)), 16'd400,
                    16'd120, 3'($urandom_range(1, 6)), 16'($urandom_range(1, 20)));
    run_traffic_phase(32'h8000_4000, RANDOM_ITEMS_PER_PHASE, 1'b1);
  endtask

  initial begin
    new_block_sec = srlb_pkg::BLOCK_NEW_RST; repeat_block_sec = srlb_pkg::BLOCK_REPEAT_RST;
    fast_gap_ms = srlb_pkg::FAST_MS_RST; calm_gap_ms = srlb_pkg::CALM_MS_RST;
    viol_limit = srlb_pkg::MAX_VIOL_RST; idle_limit_sec = srlb_pkg::IDLE_SEC_RST;
    foreach (listed_v[i]) listed_v[i] = 1'b0;
    foreach (tracked_v[i]) tracked_v[i] = 1'b0;
    foreach (verdict_seen[i]) verdict_seen[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_behaviour();
    test_tables_full();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d packets, %0d verdicts over five register settings",
             packets_sent, verdicts_checked);
    $display("listed %0d, bad sig %0d, too fast %0d, passed %0d, bad cmd %0d, full %0d",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
             verdict_seen[4], full_seen);
    if (fails == 0 && decision_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
